[rtl/core/fprt_pkg.sv]
package fprt_pkg;

	localparam int unsigned FIELD_W  = 16;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned OFFSET_W = 18;
	localparam int unsigned COUNT_W  = 9;

	localparam logic [FIELD_W-1:0] MAGIC_RESET = 16'hAA55;
	localparam logic [FIELD_W-1:0] NO_FRAME    = 16'hFFFF;

	typedef enum logic [STATUS_W-1:0] {
		ST_BAD_MAGIC = 3'd0,
		ST_BAD_INDEX = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_NEW       = 3'd3,
		ST_DUP       = 3'd4
	} status_t;

	typedef struct packed {
		logic [FIELD_W-1:0] magic;
		logic [FIELD_W-1:0] frame_number;
		logic [FIELD_W-1:0] packet_index;
		logic [FIELD_W-1:0] packet_count;
		logic [FIELD_W-1:0] payload_bytes;
	} hdr_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OFFSET_W-1:0] write_offset;
		logic                frame_done;
		logic [FIELD_W-1:0]  done_frame_number;
	} res_t;

	// state update decided for one header
	typedef struct packed {
		logic               open;
		logic               accept;
		logic               mark;
		logic               done;
		logic [FIELD_W-1:0] frame;
		logic [FIELD_W-1:0] total;
		logic [COUNT_W-1:0] count_next;
	} upd_t;

	typedef struct packed {
		logic [FIELD_W-1:0] active;
		logic [FIELD_W-1:0] total;
		logic [COUNT_W-1:0] count;
	} trk_t;

endpackage

[rtl/core/fprt_hdr_if.sv]
interface fprt_hdr_if;
	logic        valid;
	logic        ready;
	logic [15:0] magic;
	logic [15:0] frame_number;
	logic [15:0] packet_index;
	logic [15:0] packet_count;
	logic [15:0] payload_bytes;

	modport source (
		output valid, magic, frame_number, packet_index, packet_count, payload_bytes,
		input  ready
	);
	modport sink (
		input  valid, magic, frame_number, packet_index, packet_count, payload_bytes,
		output ready
	);
endinterface

[rtl/core/fprt_res_if.sv]
interface fprt_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [17:0] write_offset;
	logic        frame_done;
	logic [15:0] done_frame_number;

	modport source (
		output valid, status, write_offset, frame_done, done_frame_number,
		input  ready
	);
	modport sink (
		input  valid, status, write_offset, frame_done, done_frame_number,
		output ready
	);
endinterface

[rtl/core/fprt_eval.sv]
module fprt_eval #(
	parameter int unsigned SLOT_BYTES  = 1024,
	parameter int unsigned FRAME_BYTES = 153600,
	parameter int unsigned MAX_SLOTS   = 256
) (
	input  fprt_pkg::hdr_t                         hdr,
	input  logic [fprt_pkg::FIELD_W-1:0]           magic_value,
	input  fprt_pkg::trk_t                         trk,
	input  logic [MAX_SLOTS-1:0]                   map,
	output logic [$clog2(MAX_SLOTS)-1:0]           slot,
	output fprt_pkg::res_t                         res,
	output fprt_pkg::upd_t                         upd
);
	localparam int unsigned SLOT_W  = $clog2(MAX_SLOTS);
	localparam int unsigned SPAN_W  = $clog2(MAX_SLOTS * SLOT_BYTES + 65536) + 1;
	localparam int unsigned FRAME_W = $clog2(FRAME_BYTES + 1);
	localparam int unsigned SUM_W   = (SPAN_W > FRAME_W) ? SPAN_W : FRAME_W;

	logic                             magic_ok;
	logic                             slot_ok;
	logic                             is_new;
	logic                             seen;
	logic                             overflow;
	logic                             done;
	logic [SUM_W-1:0]                 offset;
	logic [SUM_W-1:0]                 span_end;
	logic [fprt_pkg::FIELD_W-1:0]     total_eff;
	logic [fprt_pkg::COUNT_W-1:0]     count_eff;
	logic [fprt_pkg::COUNT_W-1:0]     count_next;

	assign slot     = hdr.packet_index[SLOT_W-1:0];
	assign magic_ok = (hdr.magic == magic_value);
	assign slot_ok  = (hdr.packet_index < fprt_pkg::FIELD_W'(MAX_SLOTS));
	assign is_new   = (hdr.frame_number != trk.active);

	// a new frame id sees a cleared count and bitmap
	assign total_eff = is_new ? hdr.packet_count : trk.total;
	assign count_eff = is_new ? '0 : trk.count;
	assign seen      = is_new ? 1'b0 : map[slot];

	assign offset   = SUM_W'(slot) * SUM_W'(SLOT_BYTES);
	assign span_end = offset + SUM_W'(hdr.payload_bytes);
	assign overflow = (span_end > SUM_W'(FRAME_BYTES));

	assign count_next = seen ? count_eff : count_eff + fprt_pkg::COUNT_W'(1);
	assign done       = (fprt_pkg::FIELD_W'(count_next) == total_eff);

	always_comb begin
		res = '0;
		upd = '0;
		upd.frame      = hdr.frame_number;
		upd.total      = hdr.packet_count;
		upd.count_next = count_next;
		if (!magic_ok) begin
			res.status = fprt_pkg::ST_BAD_MAGIC;
		end else if (!slot_ok) begin
			res.status = fprt_pkg::ST_BAD_INDEX;
		end else begin
			upd.open = is_new;
			if (overflow) begin
				res.status = fprt_pkg::ST_OVERFLOW;
			end else begin
				upd.accept       = 1'b1;
				upd.mark         = !seen;
				upd.done         = done;
				res.status       = seen ? fprt_pkg::ST_DUP : fprt_pkg::ST_NEW;
				res.write_offset = offset[fprt_pkg::OFFSET_W-1:0];
				res.frame_done   = done;
				if (done) begin
					res.done_frame_number = hdr.frame_number;
				end
			end
		end
	end

endmodule

[rtl/core/fprt_state.sv]
module fprt_state #(
	parameter int unsigned MAX_SLOTS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  fprt_pkg::upd_t                upd,
	input  logic [$clog2(MAX_SLOTS)-1:0]  slot,
	output fprt_pkg::trk_t                trk,
	output logic [MAX_SLOTS-1:0]          map
);
	logic [fprt_pkg::FIELD_W-1:0] active_q;
	logic [fprt_pkg::FIELD_W-1:0] total_q;
	logic [fprt_pkg::COUNT_W-1:0] count_q;
	logic [MAX_SLOTS-1:0]         map_q;
	logic [fprt_pkg::COUNT_W-1:0] count_d;
	logic [MAX_SLOTS-1:0]         map_d;

	always_comb begin
		map_d = upd.open ? '0 : map_q;
		// set after the clear so a new frame keeps its first slot
		if (upd.mark) begin
			map_d[slot] = 1'b1;
		end
		if (upd.accept) begin
			count_d = upd.count_next;
		end else if (upd.open) begin
			count_d = '0;
		end else begin
			count_d = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= fprt_pkg::NO_FRAME;
			total_q  <= '0;
			count_q  <= '0;
			map_q    <= '0;
		end else if (en) begin
			if (upd.open) begin
				total_q <= upd.total;
			end
			count_q <= count_d;
			map_q   <= map_d;
			if (upd.done) begin
				active_q <= fprt_pkg::NO_FRAME;
			end else if (upd.open) begin
				active_q <= upd.frame;
			end
		end
	end

	assign trk.active = active_q;
	assign trk.total  = total_q;
	assign trk.count  = count_q;
	assign map        = map_q;

endmodule

[rtl/core/frame_packet_reassembly_tracker_unit.sv]
// Packet reassembly tracker: takes one packet header per cycle and returns one
// result item per header. A header is registered in hdr_s1, its result in res_q.
// The header is checked against the magic word, slot range and frame buffer end,
// and the frame's received bitmap is read and updated in the same cycle, so the
// next header sees the updated bitmap with no gap. Sustained rate is one item per
// clock while the result side takes items; while one result waits, the input
// still takes one more header before it stalls. A new frame id clears the bitmap
// in the same update that marks its first slot.
// The magic word is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle, which the block itself does not enforce.
module frame_packet_reassembly_tracker_unit #(
	parameter int unsigned SLOT_BYTES  = 1024,
	parameter int unsigned FRAME_BYTES = 153600,
	parameter int unsigned MAX_SLOTS   = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [fprt_pkg::FIELD_W-1:0] cfg_wr_data,
	fprt_hdr_if.sink                     hdr,
	fprt_res_if.source                   res
);
	localparam int unsigned SLOT_W = $clog2(MAX_SLOTS);

	logic [fprt_pkg::FIELD_W-1:0] magic_q;
	logic                         valid_s1;
	fprt_pkg::hdr_t               hdr_s1;
	logic                         res_valid_q;
	fprt_pkg::res_t               res_q;
	logic                         adv;
	logic [SLOT_W-1:0]            slot;
	fprt_pkg::res_t               res_d;
	fprt_pkg::upd_t               upd;
	fprt_pkg::trk_t               trk;
	logic [MAX_SLOTS-1:0]         map;

	assign adv       = valid_s1 && (!res_valid_q || res.ready);
	assign hdr.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= fprt_pkg::MAGIC_RESET;
		end else if (cfg_wr_en) begin
			magic_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr.ready) begin
			valid_s1 <= hdr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr.ready && hdr.valid) begin
			hdr_s1.magic         <= hdr.magic;
			hdr_s1.frame_number  <= hdr.frame_number;
			hdr_s1.packet_index  <= hdr.packet_index;
			hdr_s1.packet_count  <= hdr.packet_count;
			hdr_s1.payload_bytes <= hdr.payload_bytes;
		end
	end

	fprt_eval #(
		.SLOT_BYTES  (SLOT_BYTES),
		.FRAME_BYTES (FRAME_BYTES),
		.MAX_SLOTS   (MAX_SLOTS)
	) u_eval (
		.hdr         (hdr_s1),
		.magic_value (magic_q),
		.trk         (trk),
		.map         (map),
		.slot        (slot),
		.res         (res_d),
		.upd         (upd)
	);

	fprt_state #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.upd    (upd),
		.slot   (slot),
		.trk    (trk),
		.map    (map)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || res.ready) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign res.valid             = res_valid_q;
	assign res.status            = res_q.status;
	assign res.write_offset      = res_q.write_offset;
	assign res.frame_done        = res_q.frame_done;
	assign res.done_frame_number = res_q.done_frame_number;

	// a completed frame always leaves the tracker idle
	a_done_idles: assert property (@(posedge clk) disable iff (!arst_n)
		adv && upd.done |=> trk.active == fprt_pkg::NO_FRAME)
		else $error("active frame not released after completion");

	a_done_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.frame_done |->
			res.status == fprt_pkg::ST_NEW || res.status == fprt_pkg::ST_DUP)
		else $error("frame done on a dropped header");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		trk.count <= fprt_pkg::COUNT_W'(MAX_SLOTS))
		else $error("slot count beyond slot range");

	a_mark_sets: assert property (@(posedge clk) disable iff (!arst_n)
		adv && upd.mark |=> map[$past(slot)])
		else $error("bitmap bit not set for new slot");

endmodule
